@@ hw/rtl/sae_pkg.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton engine package
// Operation codes and field widths shared by the interfaces and the core.
// ----------------------------------------------------------------------------
package sae_pkg;

  localparam int ModeW  = 2;
  localparam int SymW   = 8;
  localparam int LenW   = 9;
  localparam int PosW   = 16;
  localparam int CountW = 10;

  typedef logic [ModeW-1:0] mode_t;
  typedef logic [SymW-1:0]  sym_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [CountW-1:0] count_t;

  localparam mode_t MODE_APPEND  = 2'd0;
  localparam mode_t MODE_PATTERN = 2'd1;
  localparam mode_t MODE_COMMON  = 2'd2;
  localparam mode_t MODE_CLEAR   = 2'd3;

endpackage

@@ hw/rtl/sae_in_if.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton engine input channel
// Valid/ready channel that carries one command item per transfer.
// ----------------------------------------------------------------------------
interface sae_in_if;
  import sae_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  sym_t  symbol;
  logic  first;
  logic  final_req;

  modport source (output valid, mode, symbol, first, final_req, input ready);
  modport sink (input valid, mode, symbol, first, final_req, output ready);
endinterface

@@ hw/rtl/sae_out_if.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton engine output channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface sae_out_if;
  import sae_pkg::*;

  logic   valid;
  logic   ready;
  logic   found;
  len_t   match_len;
  len_t   best_len;
  pos_t   best_end;
  count_t state_count;
  logic   text_full;
  logic   query_done;

  modport source (output valid, found, match_len, best_len, best_end, state_count,
                  text_full, query_done, input ready);
  modport sink (input valid, found, match_len, best_len, best_end, state_count,
                text_full, query_done, output ready);
endinterface

@@ hw/rtl/suffix_automaton_engine_core.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton engine core
// Builds a suffix automaton of a text symbol by symbol and answers streamed
// pattern and common-substring queries against it.
//
// Each transfer on item carries a mode, a symbol and the first/final flags of
// a query. Every item produces exactly one transfer on result. Items are taken
// one at a time; a finished result sits in an output register, so the next
// item is taken while the receiver stalls, and the core waits only when a
// second result is ready before the first has been taken.
// A common-substring step climbs suffix links until a transition is found. An
// append visits suffix links, and a clone also checks states for redirection;
// the time of both is set by the single write port of the transition memory
// that clears each new row and copies the cloned row. A clear clears the root
// row. After reset the root row is cleared, during which no item is taken.
// ----------------------------------------------------------------------------
module suffix_automaton_engine_core #(
  parameter int MAX_TEXT  = 256,
  parameter int ALPHABET  = 256,
  parameter int MAX_QUERY = 65536
) (
  input  logic clk,
  input  logic rst,
  sae_in_if.sink    item,
  sae_out_if.source result
);
  import sae_pkg::*;

  localparam int MaxStates = 2 * MAX_TEXT;
  localparam int SW = $clog2(MaxStates);
  localparam int CW = $clog2(MaxStates + 1);
  localparam int LW = $clog2(MAX_TEXT + 1);
  localparam int QW = $clog2(MAX_QUERY);
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int KW = AW + 1;
  localparam int TD = MaxStates * (2 ** AW);
  localparam int NW = LW + SW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RCLR  = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_ARD   = 5'd3;
  localparam logic [4:0] S_ACHK  = 5'd4;
  localparam logic [4:0] S_ARDQ  = 5'd5;
  localparam logic [4:0] S_ACHKQ = 5'd6;
  localparam logic [4:0] S_CLNQ  = 5'd7;
  localparam logic [4:0] S_CP    = 5'd8;
  localparam logic [4:0] S_RRD   = 5'd9;
  localparam logic [4:0] S_RCHK  = 5'd10;
  localparam logic [4:0] S_FIN   = 5'd11;
  localparam logic [4:0] S_PRD   = 5'd12;
  localparam logic [4:0] S_PCHK  = 5'd13;
  localparam logic [4:0] S_CRD   = 5'd14;
  localparam logic [4:0] S_CCHK  = 5'd15;
  localparam logic [4:0] S_CRDT  = 5'd16;
  localparam logic [4:0] S_CCHKT = 5'd17;
  localparam logic [4:0] S_CBEST = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [SW-1:0] trans_mem [TD];
  logic [NW-1:0] node_mem [MaxStates];

  logic [4:0]    st;
  logic [SW-1:0] last_state;
  logic [LW-1:0] last_len;
  logic [CW-1:0] states_used;
  logic [SW-1:0] qs;
  logic          qfound;
  logic [LW-1:0] cur_len;
  logic [LW-1:0] best_len;
  logic [QW-1:0] best_pos;
  logic [QW-1:0] qpos;
  logic          ovf;
  logic          fin;
  logic [AW-1:0] c;
  logic [SW-1:0] cur;
  logic [LW-1:0] cur_l;
  logic [SW-1:0] p;
  logic [SW-1:0] q;
  logic [SW-1:0] cl;
  logic [SW-1:0] lnk;
  logic [LW-1:0] len_p;
  logic [LW-1:0] len_q;
  logic [LW:0]   inc_len;
  logic          pend;
  logic          post_done;
  logic [KW-1:0] cnt;
  logic          ovalid;

  logic          t_re;
  logic [SW+AW-1:0] t_raddr;
  logic [SW-1:0] t_rdata;
  logic          t_we;
  logic [SW+AW-1:0] t_waddr;
  logic [SW-1:0] t_wdata;
  logic          n_re;
  logic [SW-1:0] n_raddr;
  logic [NW-1:0] n_rdata;
  logic          n_zero;
  logic          n_we;
  logic [SW-1:0] n_waddr;
  logic [NW-1:0] n_wdata;

  logic [LW-1:0] len_rd;
  logic [SW-1:0] link_rd;
  logic [LW-1:0] c_base;
  logic          sym_bad;
  logic [CW:0]   used_plus2;
  logic [KW-1:0] alpha_k;
  logic [KW-1:0] alpha_last;
  logic [31:0]   su32;
  logic [31:0]   cl32;
  logic [31:0]   bl32;
  logic [31:0]   bp32;

  assign len_rd     = n_zero ? '0 : n_rdata[NW-1:SW];
  assign link_rd    = n_rdata[SW-1:0];
  assign c_base     = pend ? len_rd : cur_len;
  assign sym_bad    = {1'b0, item.symbol} >= 9'(ALPHABET);
  assign used_plus2 = {1'b0, states_used} + (CW+1)'(2);
  assign alpha_k    = KW'(ALPHABET);
  assign alpha_last = KW'(ALPHABET - 1);
  assign su32 = 32'(states_used);
  assign cl32 = 32'(cur_len);
  assign bl32 = 32'(best_len);
  assign bp32 = 32'(best_pos);

  assign item.ready = (st == S_IDLE);
  assign result.valid = ovalid;

  always_comb begin
    t_re    = 1'b0;
    t_raddr = {p, c};
    t_we    = 1'b0;
    t_waddr = {p, c};
    t_wdata = '0;
    n_re    = 1'b0;
    n_raddr = p;
    n_we    = 1'b0;
    n_waddr = cur;
    n_wdata = {cur_l, lnk};
    case (st)
      S_RCLR: begin
        t_we    = 1'b1;
        t_waddr = {{SW{1'b0}}, cnt[AW-1:0]};
      end
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = {cur, cnt[AW-1:0]};
      end
      S_ARD, S_RRD: begin
        t_re = 1'b1;
        n_re = 1'b1;
      end
      S_ACHK: begin
        t_we    = (t_rdata == '0);
        t_wdata = cur;
      end
      S_ARDQ: begin
        n_re    = 1'b1;
        n_raddr = q;
      end
      S_ACHKQ: begin
        n_we    = ((LW+1)'(len_p) + (LW+1)'(1)) != (LW+1)'(len_rd);
        n_waddr = states_used[SW-1:0];
        n_wdata = {LW'(len_p + LW'(1)), link_rd};
      end
      S_CLNQ: begin
        n_we    = 1'b1;
        n_waddr = q;
        n_wdata = {len_q, cl};
      end
      S_CP: begin
        t_re    = (cnt != alpha_k);
        t_raddr = {q, cnt[AW-1:0]};
        t_we    = (cnt != '0);
        t_waddr = {cl, AW'(cnt - KW'(1))};
        t_wdata = t_rdata;
      end
      S_RCHK: begin
        t_we    = (t_rdata == q);
        t_wdata = cl;
      end
      S_FIN: begin
        n_we = 1'b1;
      end
      S_PRD, S_CRD: begin
        t_re    = 1'b1;
        t_raddr = {qs, c};
        n_re    = (st == S_CRD);
        n_raddr = qs;
      end
      S_CRDT: begin
        n_re    = 1'b1;
        n_raddr = qs;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      trans_mem[t_waddr] <= t_wdata;
    end
    if (t_re) begin
      t_rdata <= trans_mem[t_raddr];
    end
    if (n_we) begin
      node_mem[n_waddr] <= n_wdata;
    end
    if (n_re) begin
      n_rdata <= node_mem[n_raddr];
      n_zero  <= (n_raddr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_RCLR;
      cnt         <= '0;
      post_done   <= 1'b0;
      last_state  <= '0;
      last_len    <= '0;
      states_used <= CW'(1);
      qs          <= '0;
      qfound      <= 1'b1;
      cur_len     <= '0;
      best_len    <= '0;
      best_pos    <= '0;
      qpos        <= '0;
      ovf         <= 1'b0;
      pend        <= 1'b0;
      ovalid      <= 1'b0;
    end else begin
      if (ovalid && result.ready) begin
        ovalid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (item.valid) begin
            c   <= item.symbol[AW-1:0];
            fin <= item.final_req;
            case (item.mode)
              MODE_APPEND: begin
                if (sym_bad) begin
                  st <= S_DONE;
                end else if (last_len >= LW'(MAX_TEXT) ||
                             used_plus2 > (CW+1)'(MaxStates)) begin
                  ovf <= 1'b1;
                  st  <= S_DONE;
                end else begin
                  cur         <= states_used[SW-1:0];
                  states_used <= states_used + CW'(1);
                  cur_l       <= last_len + LW'(1);
                  p           <= last_state;
                  lnk         <= '0;
                  cnt         <= '0;
                  st          <= S_CLR;
                end
              end
              MODE_PATTERN: begin
                if (item.first) begin
                  qs     <= '0;
                  qfound <= 1'b1;
                end
                if (!(item.first || qfound)) begin
                  st <= S_DONE;
                end else if (sym_bad) begin
                  qfound <= 1'b0;
                  st     <= S_DONE;
                end else begin
                  st <= S_PRD;
                end
              end
              MODE_COMMON: begin
                pend <= 1'b0;
                if (item.first) begin
                  qs       <= '0;
                  cur_len  <= '0;
                  best_len <= '0;
                  best_pos <= '0;
                  qpos     <= '0;
                end
                if (sym_bad) begin
                  qs      <= '0;
                  cur_len <= '0;
                  st      <= S_CBEST;
                end else begin
                  st <= S_CRD;
                end
              end
              default: begin
                last_state  <= '0;
                last_len    <= '0;
                states_used <= CW'(1);
                qs          <= '0;
                qfound      <= 1'b1;
                cur_len     <= '0;
                best_len    <= '0;
                best_pos    <= '0;
                qpos        <= '0;
                ovf         <= 1'b0;
                cnt         <= '0;
                post_done   <= 1'b1;
                st          <= S_RCLR;
              end
            endcase
          end
        end
        S_RCLR: begin
          cnt <= cnt + KW'(1);
          if (cnt == alpha_last) begin
            st <= post_done ? S_DONE : S_IDLE;
          end
        end
        S_CLR: begin
          cnt <= cnt + KW'(1);
          if (cnt == alpha_last) begin
            st <= S_ARD;
          end
        end
        S_ARD: st <= S_ACHK;
        S_ACHK: begin
          len_p <= len_rd;
          if (t_rdata == '0) begin
            if (p == '0) begin
              lnk <= '0;
              st  <= S_FIN;
            end else begin
              p  <= link_rd;
              st <= S_ARD;
            end
          end else begin
            q  <= t_rdata;
            st <= S_ARDQ;
          end
        end
        S_ARDQ: st <= S_ACHKQ;
        S_ACHKQ: begin
          if (((LW+1)'(len_p) + (LW+1)'(1)) == (LW+1)'(len_rd)) begin
            lnk <= q;
            st  <= S_FIN;
          end else begin
            cl          <= states_used[SW-1:0];
            lnk         <= states_used[SW-1:0];
            states_used <= states_used + CW'(1);
            len_q       <= len_rd;
            cnt         <= '0;
            st          <= S_CLNQ;
          end
        end
        S_CLNQ: st <= S_CP;
        S_CP: begin
          cnt <= cnt + KW'(1);
          if (cnt == alpha_k) begin
            st <= S_RRD;
          end
        end
        S_RRD: st <= S_RCHK;
        S_RCHK: begin
          if (t_rdata == q && p != '0) begin
            p  <= link_rd;
            st <= S_RRD;
          end else begin
            st <= S_FIN;
          end
        end
        S_FIN: begin
          last_state <= cur;
          last_len   <= cur_l;
          st         <= S_DONE;
        end
        S_PRD: st <= S_PCHK;
        S_PCHK: begin
          if (t_rdata == '0) begin
            qfound <= 1'b0;
          end else begin
            qs <= t_rdata;
          end
          st <= S_DONE;
        end
        S_CRD: st <= S_CCHK;
        S_CCHK: begin
          if (t_rdata == '0) begin
            if (qs != '0) begin
              qs   <= link_rd;
              pend <= 1'b1;
              st   <= S_CRD;
            end else begin
              cur_len <= '0;
              st      <= S_CBEST;
            end
          end else begin
            qs      <= t_rdata;
            inc_len <= (LW+1)'(c_base) + (LW+1)'(1);
            st      <= S_CRDT;
          end
        end
        S_CRDT: st <= S_CCHKT;
        S_CCHKT: begin
          if (inc_len > (LW+1)'(len_rd)) begin
            cur_len <= len_rd;
          end else begin
            cur_len <= inc_len[LW-1:0];
          end
          st <= S_CBEST;
        end
        S_CBEST: begin
          if (cur_len > best_len) begin
            best_len <= cur_len;
            best_pos <= qpos;
          end
          if (qpos < QW'(MAX_QUERY - 1)) begin
            qpos <= qpos + QW'(1);
          end
          st <= S_DONE;
        end
        S_DONE: begin
          if (!ovalid || result.ready) begin
            ovalid             <= 1'b1;
            result.found       <= qfound;
            result.match_len   <= cl32[LenW-1:0];
            result.best_len    <= bl32[LenW-1:0];
            result.best_end    <= bp32[PosW-1:0];
            result.state_count <= su32[CountW-1:0];
            result.text_full   <= ovf;
            result.query_done  <= fin;
            st                 <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    states_used >= CW'(1) && states_used <= CW'(MaxStates))
    else $error("state count out of range");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    cur_len <= LW'(MAX_TEXT) && last_len <= LW'(MAX_TEXT))
    else $error("length beyond text capacity");

  a_best_cover: assert property (@(posedge clk) disable iff (rst)
    st == S_IDLE |-> best_len >= cur_len)
    else $error("best length below current length");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (st == S_DONE && (!ovalid || result.ready)) |=> (ovalid && st == S_IDLE))
    else $error("finished result not presented");

  a_clone_grows: assert property (@(posedge clk) disable iff (rst)
    st == S_CLNQ |-> $past(states_used) + CW'(1) == states_used)
    else $error("clone did not take a new state");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Suffix automaton engine core testbench
// Drives appends, pattern steps, common-substring steps and clears through
// the item channel with random gaps and result stalls, tracks the automaton
// in a local copy and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb;
  import sae_pkg::*;

  localparam int TextMax   = 256;
  localparam int SymCount  = 256;
  localparam int QueryMax  = 65536;
  localparam int StateMax  = 2 * TextMax;
  localparam int NoLink    = -1;
  localparam int CycleLimit = 6000000;
  localparam int LongLen   = 150;
  localparam int Rounds    = 20;

  typedef struct packed {
    logic   found;
    len_t   match_len;
    len_t   best_len;
    pos_t   best_end;
    count_t state_count;
    logic   text_full;
    logic   query_done;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors = 0;
  bit   no_gaps = 1'b0;
  int   hold_len = 0;

  sae_in_if  item ();
  sae_out_if result ();

  suffix_automaton_engine_core #(
    .MAX_TEXT(TextMax),
    .ALPHABET(SymCount),
    .MAX_QUERY(QueryMax)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("suffix_automaton_engine_core test failed");
      $finish;
    end
  end

  // Local copy of the automaton.
  int       next_tab [0:StateMax*SymCount-1];
  int       st_len [0:StateMax-1];
  int       st_link [0:StateMax-1];
  int       last_st, used, walk_st, walk_found, cur_len, top_len, top_pos, walk_pos;
  int       full_flag;
  outcome_t pending_results[$];

  function automatic void clear_row(int s);
    for (int i = 0; i < SymCount; i++) next_tab[s*SymCount+i] = 0;
  endfunction

  function automatic void clear_automaton();
    clear_row(0);
    st_len[0] = 0;
    st_link[0] = NoLink;
    last_st = 0; used = 1; walk_st = 0; walk_found = 1; cur_len = 0;
    top_len = 0; top_pos = 0; walk_pos = 0; full_flag = 0;
  endfunction

  function automatic int make_state();
    int s;
    s = used % StateMax;
    used++;
    clear_row(s);
    st_len[s] = 0;
    st_link[s] = 0;
    return s;
  endfunction

  function automatic void extend_text(int c);
    int cur, p, q, cl;
    if (st_len[last_st] >= TextMax || used + 2 > StateMax) begin
      full_flag = 1;
      return;
    end
    cur = make_state();
    st_len[cur] = st_len[last_st] + 1;
    p = last_st;
    while (p != NoLink && next_tab[p*SymCount+c] == 0) begin
      next_tab[p*SymCount+c] = cur;
      p = st_link[p];
    end
    if (p == NoLink) begin
      st_link[cur] = 0;
    end else begin
      q = next_tab[p*SymCount+c];
      if (st_len[p] + 1 == st_len[q]) begin
        st_link[cur] = q;
      end else begin
        cl = make_state();
        for (int i = 0; i < SymCount; i++) next_tab[cl*SymCount+i] = next_tab[q*SymCount+i];
        st_len[cl] = st_len[p] + 1;
        st_link[cl] = st_link[q];
        st_link[q] = cl;
        while (p != NoLink && next_tab[p*SymCount+c] == q) begin
          next_tab[p*SymCount+c] = cl;
          p = st_link[p];
        end
        st_link[cur] = cl;
      end
    end
    last_st = cur;
  endfunction

  function automatic void match_pattern(int c, bit first);
    int t;
    if (first) begin
      walk_st = 0;
      walk_found = 1;
    end
    if (!walk_found) return;
    t = next_tab[walk_st*SymCount+c];
    if (t == 0) walk_found = 0;
    else walk_st = t;
  endfunction

  function automatic void match_common(int c, bit first);
    int t;
    if (first) begin
      walk_st = 0; cur_len = 0; top_len = 0; top_pos = 0; walk_pos = 0;
    end
    while (walk_st != 0 && next_tab[walk_st*SymCount+c] == 0) begin
      walk_st = st_link[walk_st];
      cur_len = st_len[walk_st];
    end
    t = next_tab[walk_st*SymCount+c];
    if (t != 0) begin
      walk_st = t;
      cur_len++;
      if (cur_len > st_len[walk_st]) cur_len = st_len[walk_st];
    end else begin
      cur_len = 0;
    end
    if (cur_len > top_len) begin
      top_len = cur_len;
      top_pos = walk_pos;
    end
    if (walk_pos < QueryMax - 1) walk_pos++;
  endfunction

  function automatic void advance_automaton(mode_t m, sym_t s, bit first, bit fin);
    outcome_t o;
    case (m)
      MODE_APPEND:  extend_text(int'(s));
      MODE_PATTERN: match_pattern(int'(s), first);
      MODE_COMMON:  match_common(int'(s), first);
      default:      clear_automaton();
    endcase
    o.found = walk_found[0];
    o.match_len = len_t'(cur_len);
    o.best_len = len_t'(top_len);
    o.best_end = pos_t'(top_pos);
    o.state_count = count_t'(used);
    o.text_full = full_flag[0];
    o.query_done = fin;
    pending_results = {pending_results, o};
  endfunction

  task automatic send_item(mode_t m, sym_t s, bit first, bit fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.mode <= m;
    item.symbol <= s;
    item.first <= first;
    item.final_req <= fin;
    do @(posedge clk); while (!item.ready);
    advance_automaton(m, s, first, fin);
  endtask

  task automatic send_text(sym_t text[$]);
    foreach (text[i]) send_item(MODE_APPEND, text[i], 1'b0, 1'b0);
  endtask

  task automatic send_query(mode_t m, sym_t text[$]);
    foreach (text[i]) send_item(m, text[i], i == 0, i == text.size() - 1);
  endtask

  // Result side: random stalls, or a long hold when one is requested.
  initial begin
    int stall;
    result.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = hold_len > 0 ? hold_len : (no_gaps ? 0 : $urandom_range(0, 6));
      hold_len = 0;
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result");
        errors++;
      end else begin
        outcome_t e;
        e = pending_results.pop_front();
        if (result.found !== e.found) begin
          $error("found: expected %0d, actual %0d", e.found, result.found); errors++;
        end
        if (result.match_len !== e.match_len) begin
          $error("match_len: expected %0d, actual %0d", e.match_len, result.match_len);
          errors++;
        end
        if (result.best_len !== e.best_len) begin
          $error("best_len: expected %0d, actual %0d", e.best_len, result.best_len); errors++;
        end
        if (result.best_end !== e.best_end) begin
          $error("best_end: expected %0d, actual %0d", e.best_end, result.best_end); errors++;
        end
        if (result.state_count !== e.state_count) begin
          $error("state_count: expected %0d, actual %0d", e.state_count, result.state_count);
          errors++;
        end
        if (result.text_full !== e.text_full) begin
          $error("text_full: expected %0d, actual %0d", e.text_full, result.text_full);
          errors++;
        end
        if (result.query_done !== e.query_done) begin
          $error("query_done: expected %0d, actual %0d", e.query_done, result.query_done);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_text('{8'h61, 8'h62, 8'h62, 8'h00, 8'hFF, 8'h62});
    send_query(MODE_PATTERN, '{8'h62, 8'h62});
    send_query(MODE_PATTERN, '{8'h62, 8'h61, 8'h62});
    send_item(MODE_PATTERN, 8'hFF, 1'b0, 1'b1);
    send_query(MODE_COMMON, '{8'h62, 8'h62, 8'h00, 8'hFF, 8'h61, 8'h62, 8'h62});
    send_item(MODE_COMMON, 8'h62, 1'b0, 1'b1);
    send_item(MODE_PATTERN, 8'h62, 1'b0, 1'b0);
    send_item(MODE_CLEAR, 8'h00, 1'b1, 1'b1);
    send_query(MODE_PATTERN, '{8'h61});
    send_query(MODE_COMMON, '{8'h61});
  endtask

  task automatic test_text_full();
    send_item(MODE_CLEAR, 8'h00, 1'b0, 1'b0);
    for (int i = 0; i < TextMax + 4; i++) send_item(MODE_APPEND, sym_t'($urandom_range(0, 3)),
                                                   1'b0, 1'b0);
    send_query(MODE_COMMON, '{8'h00, 8'h01, 8'h02});
    send_item(MODE_CLEAR, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_long_query();
    send_text('{8'h10, 8'h11});
    no_gaps = 1'b1;
    for (int i = 0; i < LongLen; i++)
      send_item(MODE_COMMON, sym_t'(8'h10 + i % 3), i == 0, 1'b0);
    no_gaps = 1'b0;
    send_item(MODE_CLEAR, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    send_text('{8'h41, 8'h42});
    for (int i = 0; i < 20; i++) send_item(MODE_PATTERN, 8'h41, 1'b1, 1'b1);
  endtask

  task automatic test_random();
    sym_t text[$];
    sym_t q[$];
    int   k, a, b;
    for (int round = 0; round < Rounds; round++) begin
      text.delete();
      no_gaps = ($urandom_range(0, 7) == 0);
      send_item(MODE_CLEAR, sym_t'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      k = $urandom_range(1, 20);
      for (int i = 0; i < k; i++)
        text = {text, ($urandom_range(0, 9) == 0 ? sym_t'($urandom) :
                       sym_t'($urandom_range(97, 100)))};
      send_text(text);
      for (int j = 0; j < 3; j++) begin
        q.delete();
        a = $urandom_range(0, k - 1);
        b = $urandom_range(a, k - 1);
        for (int i = a; i <= b; i++) q = {q, text[i]};
        if ($urandom_range(0, 2) == 0) q = {q, sym_t'($urandom_range(97, 100))};
        send_query($urandom_range(0, 1) ? MODE_PATTERN : MODE_COMMON, q);
      end
      for (int i = 0; i < 3; i++)
        send_item(mode_t'($urandom_range(0, 2)), sym_t'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    item.valid <= 1'b0;
    item.mode <= MODE_APPEND;
    item.symbol <= '0;
    item.first <= 1'b0;
    item.final_req <= 1'b0;
    clear_automaton();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_text_full();
    test_backpressure();
    test_random();
    test_long_query();
    @(posedge clk);
    item.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("suffix_automaton_engine_core test passed");
    end else begin
      $display("suffix_automaton_engine_core test failed");
    end
    $finish;
  end
endmodule
